[sv/pet_pkg.sv]
// shared types and constants of the prewitt edge threshold core
package pet_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned THR_W         = 11;
  localparam int unsigned WID_W         = 11;
  localparam int unsigned HGT_W         = 12;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned SUM_W         = 10;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned SQ_W          = 20;
  localparam int unsigned MAG_W         = 21;
  localparam int unsigned THR2_W        = 22;

  localparam logic [THR_W-1:0]  THR_RST  = 11'd70;
  localparam logic [WID_W-1:0]  WID_RST  = 11'd10;
  localparam logic [HGT_W-1:0]  HGT_RST  = 12'd10;
  localparam logic [THR2_W-1:0] THR2_RST = 22'd4900;
  localparam int unsigned       MIN_DIM  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;
  } pet_in_t;

  typedef struct packed {
    logic edge_res;
    logic last_of_frame;
  } pet_out_t;

  // rows [2:0] top to bottom, columns [2:0] left to right
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic vld;
    logic last;
  } win_ctrl_t;

endpackage

[sv/prewitt_edge_threshold_core.sv]
// top level of the prewitt edge threshold core: configuration and datapath
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    in_data_i  (pixel, start_of_frame)
//  out      output     out_valid_o / out_stall_i  out_data_o (edge_res, last_of_frame)
//  cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one pixel per cycle while in_stall_o is low; a pixel passes s1, the window, then a, b, c
// the line store is read at accept; s1 writes that entry back when the window advances
// reset clears counters, window and pipeline valids; the line store is not cleared
// an output stall fills the stages behind it before in_stall_o rises
module prewitt_edge_threshold_core
  import pet_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pet_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pet_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > WID_W) ? WW : WID_W;

  logic [THR_W-1:0]  thr_q;
  logic [WID_W-1:0]  wid_q;
  logic [HGT_W-1:0]  hgt_q, eff_h;
  logic [THR2_W-1:0] thr2_q, thr2_d;
  logic [CW-1:0]     wid_ext, eff_w_full;
  logic [WW-1:0]     eff_w;
  window_t           win;
  win_ctrl_t         win_ctrl;
  logic              take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
      wid_q <= WID_RST;
      hgt_q <= HGT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD:    thr_q <= cfg_data_i[THR_W-1:0];
        REG_IMAGE_WIDTH:  wid_q <= cfg_data_i[WID_W-1:0];
        REG_IMAGE_HEIGHT: hgt_q <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr2_d = {{(THR2_W - THR_W){1'b0}}, thr_q} * {{(THR2_W - THR_W){1'b0}}, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr2_q <= THR2_RST;
    end else begin
      thr2_q <= thr2_d;
    end
  end

  // clamp image size
  always_comb begin
    wid_ext = CW'(wid_q);
    if (wid_ext < CW'(MIN_DIM)) begin
      eff_w_full = CW'(MIN_DIM);
    end else if (wid_ext > CW'(MAX_WIDTH)) begin
      eff_w_full = CW'(MAX_WIDTH);
    end else begin
      eff_w_full = wid_ext;
    end
    eff_w = eff_w_full[WW-1:0];
    eff_h = (hgt_q < HGT_W'(MIN_DIM)) ? HGT_W'(MIN_DIM) : hgt_q;
  end

  pet_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .eff_w_i   (eff_w),
    .eff_h_i   (eff_h),
    .take_i    (take),
    .win_o     (win),
    .ctrl_o    (win_ctrl)
  );

  pet_mag u_mag (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_i      (win),
    .ctrl_i     (win_ctrl),
    .take_o     (take),
    .thr2_i     (thr2_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

[sv/pet_ram.sv]
// generic single-port-write, registered-read ram
module pet_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pet_window.sv]
// position counters, line store read-modify-write and 3x3 window
module pet_window
  import pet_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH),
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pet_in_t          in_data_i,
  input  logic [WW-1:0]    eff_w_i,
  input  logic [HGT_W-1:0] eff_h_i,
  input  logic             take_i,
  output window_t          win_o,
  output win_ctrl_t        ctrl_o
);

  logic [AW-1:0]    col_q, col_d, col_cur;
  logic [HGT_W-1:0] row_q, row_d, row_cur;
  logic [WW-1:0]    col_p1;
  logic [HGT_W:0]   row_p1;
  logic             col_wrap, acc, en0, en1;

  logic             s1_vld_q, s1_emit_q, s1_last_q, fwd_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_addr_q;
  logic [2*PIX_W-1:0] fwd_dat_q, rdata, rd;
  logic [PIX_W-1:0] top, mid;

  window_t   win_q;
  win_ctrl_t ctrl_q;

  assign en1 = !ctrl_q.vld || take_i;
  assign en0 = !s1_vld_q || en1;
  assign acc = in_valid_i && en0;
  assign in_stall_o = !en0;

  // position of the incoming pixel
  assign col_cur  = in_data_i.start_of_frame ? '0 : col_q;
  assign row_cur  = in_data_i.start_of_frame ? '0 : row_q;
  assign col_p1   = WW'(col_cur) + WW'(1);
  assign row_p1   = (HGT_W + 1)'(row_cur) + (HGT_W + 1)'(1);
  assign col_wrap = col_p1 >= eff_w_i;

  always_comb begin
    col_d = col_p1[AW-1:0];
    row_d = row_cur;
    if (col_wrap) begin
      col_d = '0;
      row_d = (row_p1 >= (HGT_W + 1)'(eff_h_i)) ? '0 : row_p1[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (en0) begin
        s1_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= in_data_i.pixel;
      s1_addr_q <= col_cur;
      s1_emit_q <= (row_cur >= HGT_W'(2)) && (col_cur >= AW'(2));
      s1_last_q <= (row_p1 == (HGT_W + 1)'(eff_h_i)) && (col_p1 == eff_w_i);
      // same entry written at this edge by the transaction ahead
      fwd_q     <= s1_vld_q && (col_cur == s1_addr_q);
      fwd_dat_q <= {mid, s1_pix_q};
    end
  end

  pet_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q && en1),
    .waddr_i(s1_addr_q),
    .wdata_i({mid, s1_pix_q}),
    .re_i   (acc),
    .raddr_i(col_cur),
    .rdata_o(rdata)
  );

  assign rd  = fwd_q ? fwd_dat_q : rdata;
  assign top = rd[2*PIX_W-1:PIX_W];
  assign mid = rd[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      ctrl_q <= '0;
    end else if (en1) begin
      ctrl_q.vld  <= s1_vld_q && s1_emit_q;
      ctrl_q.last <= s1_last_q;
      if (s1_vld_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= top;
        win_q[1][2] <= mid;
        win_q[2][2] <= s1_pix_q;
      end
    end
  end

  assign win_o  = win_q;
  assign ctrl_o = ctrl_q;

endmodule

[sv/pet_mag.sv]
// gradients, squared magnitude and threshold compare
module pet_mag
  import pet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  window_t           win_i,
  input  win_ctrl_t         ctrl_i,
  output logic              take_o,
  input  logic [THR2_W-1:0] thr2_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pet_out_t          out_data_o
);

  logic [SUM_W-1:0]         sum_l, sum_r, sum_t, sum_b;
  logic signed [GRAD_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [2*GRAD_W-1:0] px, py;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [MAG_W-1:0]         mag2;
  logic                     a_vld_q, a_last_q, b_vld_q, b_last_q, c_vld_q;
  logic                     en_a, en_b, en_c;
  pet_out_t                 out_q;

  assign en_c   = !c_vld_q || !out_stall_i;
  assign en_b   = !b_vld_q || en_c;
  assign en_a   = !a_vld_q || en_b;
  assign take_o = en_a;

  always_comb begin
    sum_l = SUM_W'(win_i[0][0]) + SUM_W'(win_i[1][0]) + SUM_W'(win_i[2][0]);
    sum_r = SUM_W'(win_i[0][2]) + SUM_W'(win_i[1][2]) + SUM_W'(win_i[2][2]);
    sum_t = SUM_W'(win_i[0][0]) + SUM_W'(win_i[0][1]) + SUM_W'(win_i[0][2]);
    sum_b = SUM_W'(win_i[2][0]) + SUM_W'(win_i[2][1]) + SUM_W'(win_i[2][2]);
    sx_d  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    sy_d  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
  end

  assign px   = sx_q * sx_q;
  assign py   = sy_q * sy_q;
  assign mag2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= ctrl_i.vld;
      if (en_b) b_vld_q <= a_vld_q;
      if (en_c) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      a_last_q <= ctrl_i.last;
    end
    if (en_b) begin
      sqx_q    <= px[SQ_W-1:0];
      sqy_q    <= py[SQ_W-1:0];
      b_last_q <= a_last_q;
    end
    if (en_c) begin
      out_q.edge_res      <= {1'b0, mag2} > thr2_i;
      out_q.last_of_frame <= b_last_q;
    end
  end

  assign out_valid_o = c_vld_q;
  assign out_data_o  = out_q;

endmodule
